// ----- sv/rotated_ring_point_projector_top_defines.svh -----
// Assertion macros for the rotated ring point projector.
// Used by rotated_ring_point_projector_top; expects clk and rst in scope.
`ifndef ROTATED_RING_POINT_PROJECTOR_TOP_DEFINES_SVH
`define ROTATED_RING_POINT_PROJECTOR_TOP_DEFINES_SVH

// Checks that cond holds in the same cycle whenever trig holds.
`define RRPP_ASSERT_IMP(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> cond) \
    else $error("rotated ring point projector check failed");

// Checks that seq follows in the cycles after trig.
`define RRPP_ASSERT_NEXT(lbl, trig, seq) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> seq) \
    else $error("rotated ring point projector check failed");

`endif

// ----- sv/rrpp_pkg.sv -----
// Shared types, constants and the quarter-wave sine table of the point projector.
// No dependencies.
package rrpp_pkg;

  localparam int SINE_ENTRIES = 91;
  localparam int FRAC_BITS = 7;

  localparam logic [1:0] MODE_CIRCLE = 2'd0;
  localparam logic [1:0] MODE_ORBIT  = 2'd1;
  localparam logic [1:0] MODE_AXIS   = 2'd2;

  localparam logic [8:0] DEG_90  = 9'd90;
  localparam logic [8:0] DEG_180 = 9'd180;
  localparam logic [8:0] DEG_270 = 9'd270;
  localparam logic [8:0] DEG_360 = 9'd360;

  localparam logic CFG_CENTER_X = 1'b0;
  localparam logic CFG_CENTER_Y = 1'b1;

  typedef struct packed {
    logic signed [8:0] sin_v;
    logic signed [8:0] cos_v;
  } trig_t;

  function automatic logic [7:0] quarter_sine(input logic [6:0] i);
    logic [7:0] v;
    case (i)
      7'd0: v = 8'h00;  7'd1: v = 8'h02;  7'd2: v = 8'h04;  7'd3: v = 8'h07;
      7'd4: v = 8'h09;  7'd5: v = 8'h0b;  7'd6: v = 8'h0d;  7'd7: v = 8'h10;
      7'd8: v = 8'h12;  7'd9: v = 8'h14;  7'd10: v = 8'h16; 7'd11: v = 8'h18;
      7'd12: v = 8'h1b; 7'd13: v = 8'h1d; 7'd14: v = 8'h1f; 7'd15: v = 8'h21;
      7'd16: v = 8'h23; 7'd17: v = 8'h25; 7'd18: v = 8'h28; 7'd19: v = 8'h2a;
      7'd20: v = 8'h2c; 7'd21: v = 8'h2e; 7'd22: v = 8'h30; 7'd23: v = 8'h32;
      7'd24: v = 8'h34; 7'd25: v = 8'h36; 7'd26: v = 8'h38; 7'd27: v = 8'h3a;
      7'd28: v = 8'h3c; 7'd29: v = 8'h3e; 7'd30: v = 8'h40; 7'd31: v = 8'h42;
      7'd32: v = 8'h44; 7'd33: v = 8'h46; 7'd34: v = 8'h48; 7'd35: v = 8'h49;
      7'd36: v = 8'h4b; 7'd37: v = 8'h4d; 7'd38: v = 8'h4f; 7'd39: v = 8'h51;
      7'd40: v = 8'h52; 7'd41: v = 8'h54; 7'd42: v = 8'h56; 7'd43: v = 8'h57;
      7'd44: v = 8'h59; 7'd45: v = 8'h5a; 7'd46: v = 8'h5c; 7'd47: v = 8'h5e;
      7'd48: v = 8'h5f; 7'd49: v = 8'h61; 7'd50: v = 8'h62; 7'd51: v = 8'h63;
      7'd52: v = 8'h65; 7'd53: v = 8'h66; 7'd54: v = 8'h68; 7'd55: v = 8'h69;
      7'd56: v = 8'h6a; 7'd57: v = 8'h6b; 7'd58: v = 8'h6d; 7'd59: v = 8'h6e;
      7'd60: v = 8'h6f; 7'd61: v = 8'h70; 7'd62: v = 8'h71; 7'd63: v = 8'h72;
      7'd64: v = 8'h73; 7'd65: v = 8'h74; 7'd66: v = 8'h75; 7'd67: v = 8'h76;
      7'd68: v = 8'h77; 7'd69: v = 8'h78; 7'd70: v = 8'h78; 7'd71: v = 8'h79;
      7'd72: v = 8'h7a; 7'd73: v = 8'h7a; 7'd74: v = 8'h7b; 7'd75: v = 8'h7c;
      7'd76: v = 8'h7c; 7'd77: v = 8'h7d; 7'd78: v = 8'h7d; 7'd79: v = 8'h7e;
      7'd80: v = 8'h7e; 7'd81: v = 8'h7e; 7'd82: v = 8'h7f; 7'd83: v = 8'h7f;
      7'd84: v = 8'h7f; 7'd85: v = 8'h7f; 7'd86: v = 8'h80; 7'd87: v = 8'h80;
      7'd88: v = 8'h80; 7'd89: v = 8'h80; 7'd90: v = 8'h80;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // Reduces an unsigned angle of 0..511 degrees into 0..359.
  function automatic logic [8:0] wrap_angle(input logic [8:0] a);
    return (a >= DEG_360) ? a - DEG_360 : a;
  endfunction

  // Reduces a signed point angle of -512..511 degrees into 0..359.
  function automatic logic [8:0] wrap_point(input logic signed [9:0] p);
    logic signed [10:0] e;
    logic signed [10:0] w;
    e = 11'(p);
    if (e >= 11'sd360) begin
      w = e - 11'sd360;
    end else if (e < -11'sd360) begin
      w = e + 11'sd720;
    end else if (e < 11'sd0) begin
      w = e + 11'sd360;
    end else begin
      w = e;
    end
    return w[8:0];
  endfunction

  // Sine and cosine at scale 128 for an angle of 0..359 degrees.
  function automatic trig_t trig_lookup(input logic [8:0] d);
    trig_t t;
    logic [8:0] a;
    logic [8:0] b;
    logic sn;
    logic cn;
    logic signed [8:0] ms;
    logic signed [8:0] mc;
    if (d <= DEG_90) begin
      a = d; b = DEG_90 - d; sn = 1'b0; cn = 1'b0;
    end else if (d <= DEG_180) begin
      a = DEG_180 - d; b = d - DEG_90; sn = 1'b0; cn = 1'b1;
    end else if (d <= DEG_270) begin
      a = d - DEG_180; b = DEG_270 - d; sn = 1'b1; cn = 1'b1;
    end else begin
      a = DEG_360 - d; b = d - DEG_270; sn = 1'b1; cn = 1'b0;
    end
    ms = $signed({1'b0, quarter_sine(a[6:0])});
    mc = $signed({1'b0, quarter_sine(b[6:0])});
    t.sin_v = sn ? 9'sd0 - ms : ms;
    t.cos_v = cn ? 9'sd0 - mc : mc;
    return t;
  endfunction

endpackage

// ----- sv/rotated_ring_point_projector_top.sv -----
// Rotated ring point projector: point generation, three-axis rotation, screen placement.
// Depends on rrpp_pkg and rotated_ring_point_projector_top_defines.svh.
//
// A request is taken in every cycle in which start is high; busy never rises.
// Each request gives one pixel, shown for one cycle with done high, in request
// order. The seven register stages are angle reduction, table lookup, the radius
// multiply, the point build, the rotation about X, the rotation about Y, and the
// rotation about Z with placement. The receiver cannot stall the pipeline. The
// center registers are read at the last stage, so they must be written by the
// user only while no request is in flight; the block itself does not enforce this.
`include "rotated_ring_point_projector_top_defines.svh"

module rotated_ring_point_projector_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [8:0]          cfg_data,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          mode,
  input  logic [8:0]          angle_x,
  input  logic [8:0]          angle_y,
  input  logic [8:0]          angle_z,
  input  logic [7:0]          radius,
  input  logic [5:0]          ring_radius,
  input  logic [8:0]          ring_angle,
  input  logic signed [9:0]   point_param,
  input  logic [15:0]         color,
  output logic                done,
  output logic signed [10:0]  pixel_x,
  output logic signed [10:0]  pixel_y,
  output logic [15:0]         pixel_color
);
  import rrpp_pkg::*;

  logic [8:0] center_x;
  logic [8:0] center_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= 9'd160;
      center_y <= 9'd120;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CENTER_X: center_x <= cfg_data;
        CFG_CENTER_Y: center_y <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic [6:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[5:0], start};
    end
  end

  // Stage 1: angle reduction.
  logic [8:0] ax_s1, ay_s1, az_s1, ra_s1, pa_s1;
  logic [1:0] mode_s1;
  logic [7:0] r_s1;
  logic [5:0] rr_s1;
  logic signed [9:0] pp_s1;
  logic [15:0] col_s1;

  always_ff @(posedge clk) begin
    ax_s1   <= wrap_angle(angle_x);
    ay_s1   <= wrap_angle(angle_y);
    az_s1   <= wrap_angle(angle_z);
    ra_s1   <= wrap_angle(ring_angle);
    pa_s1   <= wrap_point(point_param);
    mode_s1 <= mode;
    r_s1    <= radius;
    rr_s1   <= ring_radius;
    pp_s1   <= point_param;
    col_s1  <= color;
  end

  // Stage 2: sine and cosine lookup.
  trig_t tx_s2, ty_s2, tz_s2, tp_s2, tr_s2;
  logic [1:0] mode_s2;
  logic [7:0] r_s2;
  logic [5:0] rr_s2;
  logic signed [9:0] pp_s2;
  logic [15:0] col_s2;

  always_ff @(posedge clk) begin
    tx_s2   <= trig_lookup(ax_s1);
    ty_s2   <= trig_lookup(ay_s1);
    tz_s2   <= trig_lookup(az_s1);
    tp_s2   <= trig_lookup(pa_s1);
    tr_s2   <= trig_lookup(ra_s1);
    mode_s2 <= mode_s1;
    r_s2    <= r_s1;
    rr_s2   <= rr_s1;
    pp_s2   <= pp_s1;
    col_s2  <= col_s1;
  end

  // Stage 3: point angle times circle radius or ring radius.
  logic [7:0] rsel;
  logic signed [17:0] prod_c, prod_s;
  logic signed [9:0] a_s3, b_s3;
  trig_t tx_s3, ty_s3, tz_s3, tr_s3;
  logic [1:0] mode_s3;
  logic [7:0] r_s3;
  logic signed [9:0] pp_s3;
  logic [15:0] col_s3;

  assign rsel   = (mode_s2 == MODE_ORBIT) ? {2'b00, rr_s2} : r_s2;
  assign prod_c = 18'(tp_s2.cos_v) * 18'($signed({1'b0, rsel}));
  assign prod_s = 18'(tp_s2.sin_v) * 18'($signed({1'b0, rsel}));

  always_ff @(posedge clk) begin
    a_s3    <= prod_c[16:7];
    b_s3    <= prod_s[16:7];
    tx_s3   <= tx_s2;
    ty_s3   <= ty_s2;
    tz_s3   <= tz_s2;
    tr_s3   <= tr_s2;
    mode_s3 <= mode_s2;
    r_s3    <= r_s2;
    pp_s3   <= pp_s2;
    col_s3  <= col_s2;
  end

  // Stage 4: starting point for each mode.
  logic signed [9:0] orbit_t;
  logic signed [18:0] prod_ox, prod_oy;
  logic signed [9:0] x0_next, y0_next, z0_next;
  logic signed [9:0] x0_s4, y0_s4, z0_s4;
  trig_t tx_s4, ty_s4, tz_s4;
  logic [15:0] col_s4;

  assign orbit_t = $signed({2'b00, r_s3}) + b_s3;
  assign prod_ox = 19'(tr_s3.cos_v) * 19'(orbit_t);
  assign prod_oy = 19'(tr_s3.sin_v) * 19'(orbit_t);

  always_comb begin
    case (mode_s3)
      MODE_CIRCLE: begin
        x0_next = a_s3;
        y0_next = b_s3;
        z0_next = '0;
      end
      MODE_ORBIT: begin
        x0_next = prod_ox[16:7];
        y0_next = prod_oy[16:7];
        z0_next = a_s3;
      end
      default: begin
        x0_next = '0;
        y0_next = '0;
        z0_next = pp_s3;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    x0_s4  <= x0_next;
    y0_s4  <= y0_next;
    z0_s4  <= z0_next;
    tx_s4  <= tx_s3;
    ty_s4  <= ty_s3;
    tz_s4  <= tz_s3;
    col_s4 <= col_s3;
  end

  // Stage 5: rotation about X.
  logic signed [19:0] y1_sum, z1_sum;
  logic signed [11:0] y1_s5, z1_s5;
  logic signed [9:0] x0_s5;
  trig_t ty_s5, tz_s5;
  logic [15:0] col_s5;

  assign y1_sum = 20'(tx_s4.cos_v) * 20'(y0_s4) - 20'(tx_s4.sin_v) * 20'(z0_s4);
  assign z1_sum = 20'(tx_s4.sin_v) * 20'(y0_s4) + 20'(tx_s4.cos_v) * 20'(z0_s4);

  always_ff @(posedge clk) begin
    y1_s5  <= y1_sum[18:7];
    z1_s5  <= z1_sum[18:7];
    x0_s5  <= x0_s4;
    ty_s5  <= ty_s4;
    tz_s5  <= tz_s4;
    col_s5 <= col_s4;
  end

  // Stage 6: rotation about Y.
  logic signed [21:0] x2_sum;
  logic signed [12:0] x2_s6;
  logic signed [11:0] y1_s6;
  trig_t tz_s6;
  logic [15:0] col_s6;

  assign x2_sum = 22'(ty_s5.sin_v) * 22'(z1_s5) + 22'(ty_s5.cos_v) * 22'(x0_s5);

  always_ff @(posedge clk) begin
    x2_s6  <= x2_sum[19:7];
    y1_s6  <= y1_s5;
    tz_s6  <= tz_s5;
    col_s6 <= col_s5;
  end

  // Stage 7: rotation about Z and placement on the screen.
  logic signed [22:0] xo_sum, yo_sum;
  logic signed [15:0] xo, yo, px, py;

  assign xo_sum = 23'(tz_s6.cos_v) * 23'(x2_s6) - 23'(tz_s6.sin_v) * 23'(y1_s6);
  assign yo_sum = 23'(tz_s6.sin_v) * 23'(x2_s6) + 23'(tz_s6.cos_v) * 23'(y1_s6);
  assign xo     = xo_sum[22:7];
  assign yo     = yo_sum[22:7];
  assign px     = $signed({7'b0, center_x}) + xo;
  assign py     = $signed({7'b0, center_y}) - yo;

  always_ff @(posedge clk) begin
    pixel_x     <= px[10:0];
    pixel_y     <= py[10:0];
    pixel_color <= col_s6;
  end

  assign done = valid[6];

  `RRPP_ASSERT_IMP(a_done_from_start, done, $past(start, 7))
  `RRPP_ASSERT_NEXT(a_start_gives_done, start, ##6 done)
  `RRPP_ASSERT_IMP(a_color_carried, done, pixel_color == $past(color, 7))

endmodule

// ----- test/tb_rotated_ring_point_projector_top.sv -----
`timescale 1ns / 1ps
// Testbench for rotated_ring_point_projector_top: directed and random point requests
// checked against a bit-accurate projection predictor. Depends on rrpp_pkg and the RTL.
module tb_rotated_ring_point_projector_top;
  import rrpp_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int NUM_PHASES = 6;
  localparam int PHASE_REQUESTS = 220;

  typedef struct packed {
    logic [1:0]        mode;
    logic [8:0]        angle_x;
    logic [8:0]        angle_y;
    logic [8:0]        angle_z;
    logic [7:0]        radius;
    logic [5:0]        ring_radius;
    logic [8:0]        ring_angle;
    logic signed [9:0] point_param;
    logic [15:0]       color;
  } request_t;

  typedef struct packed {
    logic signed [10:0] x;
    logic signed [10:0] y;
    logic [15:0]        color;
  } pixel_t;

  class pixel_scoreboard;
    logic [8:0] center_x;
    logic [8:0] center_y;
    pixel_t expected_pixels[$];
    int mismatch_count;
    int qsine[SINE_ENTRIES];

    function new();
      center_x = 9'd160;
      center_y = 9'd120;
      mismatch_count = 0;
      qsine = '{
        'h00, 'h02, 'h04, 'h07, 'h09, 'h0b, 'h0d, 'h10, 'h12, 'h14, 'h16, 'h18, 'h1b,
        'h1d, 'h1f, 'h21, 'h23, 'h25, 'h28, 'h2a, 'h2c, 'h2e, 'h30, 'h32, 'h34, 'h36,
        'h38, 'h3a, 'h3c, 'h3e, 'h40, 'h42, 'h44, 'h46, 'h48, 'h49, 'h4b, 'h4d, 'h4f,
        'h51, 'h52, 'h54, 'h56, 'h57, 'h59, 'h5a, 'h5c, 'h5e, 'h5f, 'h61, 'h62, 'h63,
        'h65, 'h66, 'h68, 'h69, 'h6a, 'h6b, 'h6d, 'h6e, 'h6f, 'h70, 'h71, 'h72, 'h73,
        'h74, 'h75, 'h76, 'h77, 'h78, 'h78, 'h79, 'h7a, 'h7a, 'h7b, 'h7c, 'h7c, 'h7d,
        'h7d, 'h7e, 'h7e, 'h7e, 'h7f, 'h7f, 'h7f, 'h7f, 'h80, 'h80, 'h80, 'h80, 'h80};
    endfunction

    function int wrap_degrees(int d);
      while (d < 0) d += 360;
      while (d >= 360) d -= 360;
      return d;
    endfunction

    function int shift_down(int v);
      return v >>> FRAC_BITS;
    endfunction

    function void sin_cos(input int d, output int s, output int c);
      if (d <= 90) begin
        s = qsine[d];
        c = qsine[90 - d];
      end else if (d <= 180) begin
        s = qsine[180 - d];
        c = -qsine[d - 90];
      end else if (d <= 270) begin
        s = -qsine[d - 180];
        c = -qsine[270 - d];
      end else begin
        s = -qsine[360 - d];
        c = qsine[d - 270];
      end
    endfunction

    function pixel_t project_point(request_t q);
      pixel_t p;
      int s1, c1, s2, c2, s3, c3, s, c, s4, c4;
      int x0, y0, z0, y1, z1, x2, xo, yo, t, pp, px, py;
      pp = int'($signed(q.point_param));
      sin_cos(wrap_degrees(int'(q.angle_x)), s1, c1);
      sin_cos(wrap_degrees(int'(q.angle_y)), s2, c2);
      sin_cos(wrap_degrees(int'(q.angle_z)), s3, c3);
      if (q.mode == MODE_CIRCLE) begin
        sin_cos(wrap_degrees(pp), s, c);
        x0 = shift_down(c * int'(q.radius));
        y0 = shift_down(s * int'(q.radius));
        z0 = 0;
      end else if (q.mode == MODE_ORBIT) begin
        sin_cos(wrap_degrees(pp), s, c);
        sin_cos(wrap_degrees(int'(q.ring_angle)), s4, c4);
        z0 = shift_down(c * int'(q.ring_radius));
        t = int'(q.radius) + shift_down(s * int'(q.ring_radius));
        x0 = shift_down(c4 * t);
        y0 = shift_down(s4 * t);
      end else begin
        x0 = 0;
        y0 = 0;
        z0 = pp;
      end
      y1 = shift_down(c1 * y0 - s1 * z0);
      z1 = shift_down(s1 * y0 + c1 * z0);
      x2 = shift_down(s2 * z1 + c2 * x0);
      xo = shift_down(c3 * x2 - s3 * y1);
      yo = shift_down(s3 * x2 + c3 * y1);
      px = int'(center_x) + xo;
      py = int'(center_y) - yo;
      p.x = 11'(px);
      p.y = 11'(py);
      p.color = q.color;
      return p;
    endfunction

    function void write_center(logic index, logic [8:0] value);
      if (index == CFG_CENTER_X) center_x = value;
      else center_y = value;
    endfunction

    function void note_request(request_t q);
      expected_pixels.push_back(project_point(q));
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, actual x=%0d y=%0d color=%h",
                 $time, got.x, got.y, got.color);
        mismatch_count++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.x !== want.x) begin
        $display("%0t: pixel_x mismatch, expected %0d, actual %0d", $time, want.x, got.x);
        mismatch_count++;
      end
      if (got.y !== want.y) begin
        $display("%0t: pixel_y mismatch, expected %0d, actual %0d", $time, want.y, got.y);
        mismatch_count++;
      end
      if (got.color !== want.color) begin
        $display("%0t: pixel_color mismatch, expected %h, actual %h", $time, want.color,
                 got.color);
        mismatch_count++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_index = CFG_CENTER_X;
  logic [8:0] cfg_data = '0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] mode = MODE_CIRCLE;
  logic [8:0] angle_x = '0;
  logic [8:0] angle_y = '0;
  logic [8:0] angle_z = '0;
  logic [7:0] radius = '0;
  logic [5:0] ring_radius = '0;
  logic [8:0] ring_angle = '0;
  logic signed [9:0] point_param = '0;
  logic [15:0] color = '0;
  logic done;
  logic signed [10:0] pixel_x;
  logic signed [10:0] pixel_y;
  logic [15:0] pixel_color;

  pixel_scoreboard sb = new();
  bit idle_gaps = 1'b1;

  rotated_ring_point_projector_top u_top (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .start(start),
    .busy(busy),
    .mode(mode),
    .angle_x(angle_x),
    .angle_y(angle_y),
    .angle_z(angle_z),
    .radius(radius),
    .ring_radius(ring_radius),
    .ring_angle(ring_angle),
    .point_param(point_param),
    .color(color),
    .done(done),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .pixel_color(pixel_color)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_pixel({pixel_x, pixel_y, pixel_color});
      if (cfg_write) sb.write_center(cfg_index, cfg_data);
      if (start && !busy) begin
        sb.note_request({mode, angle_x, angle_y, angle_z, radius, ring_radius, ring_angle,
                         point_param, color});
      end
    end
  end

  task automatic send_request(input request_t q);
    @(negedge clk);
    if (idle_gaps && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    {mode, angle_x, angle_y, angle_z, radius, ring_radius, ring_angle, point_param,
     color} = q;
    start = 1'b1;
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic wait_for_pixels();
    @(negedge clk);
    start = 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_centers(input logic [8:0] cx, input logic [8:0] cy);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = CFG_CENTER_X;
    cfg_data = cx;
    @(negedge clk);
    cfg_index = CFG_CENTER_Y;
    cfg_data = cy;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  function automatic logic [8:0] random_angle();
    return ($urandom_range(0, 7) == 0) ? 9'($urandom) : 9'($urandom_range(0, 360));
  endfunction

  function automatic request_t random_request();
    request_t q;
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick < 5) q.mode = MODE_CIRCLE;
    else if (pick < 10) q.mode = MODE_ORBIT;
    else if (pick < 15) q.mode = MODE_AXIS;
    else q.mode = MODE_UNUSED;
    q.angle_x = random_angle();
    q.angle_y = random_angle();
    q.angle_z = random_angle();
    q.radius = 8'($urandom);
    q.ring_radius = 6'($urandom);
    q.ring_angle = random_angle();
    if ($urandom_range(0, 7) == 0) q.point_param = 10'($urandom);
    else if (q.mode == MODE_CIRCLE || q.mode == MODE_ORBIT)
      q.point_param = 10'($urandom_range(0, 359));
    else q.point_param = 10'(int'($urandom_range(0, 127)) - 64);
    q.color = 16'($urandom);
    return q;
  endfunction

  initial begin
    logic [8:0] phase_cx[NUM_PHASES];
    logic [8:0] phase_cy[NUM_PHASES];
    phase_cx = '{9'd0, 9'd511, 9'd0, 9'd511, 9'($urandom), 9'd160};
    phase_cy = '{9'd0, 9'd511, 9'd511, 9'd0, 9'($urandom), 9'd120};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_request('{MODE_CIRCLE, 9'd0, 9'd0, 9'd0, 8'd255, 6'd0, 9'd0, 10'sd0, 16'hffff});
    send_request('{MODE_CIRCLE, 9'd0, 9'd0, 9'd0, 8'd255, 6'd0, 9'd0, 10'sd90, 16'h0000});
    send_request('{MODE_CIRCLE, 9'd0, 9'd0, 9'd0, 8'd255, 6'd0, 9'd0, 10'sd180, 16'h8001});
    send_request('{MODE_CIRCLE, 9'd0, 9'd0, 9'd0, 8'd255, 6'd0, 9'd0, 10'sd270, 16'h7ffe});
    send_request('{MODE_CIRCLE, 9'd360, 9'd360, 9'd360, 8'd255, 6'd0, 9'd0, 10'sd359,
                   16'h1234});
    send_request('{MODE_CIRCLE, 9'd511, 9'd511, 9'd511, 8'd255, 6'd63, 9'd511, -10'sd512,
                   16'hf00f});
    send_request('{MODE_CIRCLE, 9'd90, 9'd90, 9'd90, 8'd200, 6'd0, 9'd0, 10'sd511, 16'h0ff0});
    send_request('{MODE_CIRCLE, 9'd180, 9'd270, 9'd45, 8'd255, 6'd0, 9'd0, -10'sd1, 16'haaaa});
    send_request('{MODE_CIRCLE, 9'd30, 9'd60, 9'd120, 8'd0, 6'd0, 9'd0, 10'sd45, 16'h5555});
    send_request('{MODE_ORBIT, 9'd0, 9'd0, 9'd0, 8'd255, 6'd63, 9'd0, 10'sd0, 16'h0001});
    send_request('{MODE_ORBIT, 9'd90, 9'd0, 9'd0, 8'd255, 6'd63, 9'd360, 10'sd90, 16'h0002});
    send_request('{MODE_ORBIT, 9'd0, 9'd90, 9'd0, 8'd255, 6'd63, 9'd270, 10'sd180, 16'h0004});
    send_request('{MODE_ORBIT, 9'd0, 9'd0, 9'd90, 8'd128, 6'd0, 9'd511, 10'sd270, 16'h0008});
    send_request('{MODE_ORBIT, 9'd180, 9'd180, 9'd180, 8'd0, 6'd63, 9'd180, -10'sd90,
                   16'h0010});
    send_request('{MODE_ORBIT, 9'd180, 9'd180, 9'd180, 8'd255, 6'd63, 9'd90, 10'sd90,
                   16'h5a5a});
    send_request('{MODE_AXIS, 9'd0, 9'd0, 9'd0, 8'd0, 6'd0, 9'd0, -10'sd64, 16'h0020});
    send_request('{MODE_AXIS, 9'd90, 9'd0, 9'd0, 8'd0, 6'd0, 9'd0, 10'sd63, 16'h0040});
    send_request('{MODE_AXIS, 9'd90, 9'd90, 9'd0, 8'd0, 6'd0, 9'd0, -10'sd64, 16'h0080});
    send_request('{MODE_AXIS, 9'd270, 9'd270, 9'd270, 8'd255, 6'd63, 9'd123, 10'sd511,
                   16'h0100});
    send_request('{MODE_AXIS, 9'd180, 9'd180, 9'd180, 8'd0, 6'd0, 9'd0, -10'sd512, 16'h0200});
    send_request('{MODE_UNUSED, 9'd45, 9'd30, 9'd60, 8'd77, 6'd21, 9'd200, 10'sd63, 16'h0400});

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_for_pixels();
      set_centers(phase_cx[ph], phase_cy[ph]);
      idle_gaps = (ph < NUM_PHASES - 1);
      repeat (PHASE_REQUESTS) send_request(random_request());
    end
    wait_for_pixels();

    if (sb.mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/rrpp_pkg.sv
sv/rotated_ring_point_projector_top.sv
test/tb_rotated_ring_point_projector_top.sv
